>>> rtl/core/dmf_pkg.sv
// Shared constants and register codes for the depth median filter.
`default_nettype none

package dmf_pkg;

  parameter int MAX_WIDTH_DEF  = 1024;
  parameter int MAX_HEIGHT_DEF = 1024;
  parameter int MAX_RADIUS_DEF = 3;
  parameter int DEPTH_BITS_DEF = 16;

  parameter int CFG_ADDR_W = 2;
  parameter int CFG_DATA_W = 16;

  parameter int WIDTH_REG_W  = 11;
  parameter int HEIGHT_REG_W = 11;
  parameter int RADIUS_REG_W = 2;
  parameter int MAXMOV_REG_W = 16;

  parameter logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd640;
  parameter logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 11'd480;
  parameter logic [RADIUS_REG_W-1:0] RADIUS_RST = 2'd1;
  parameter logic [MAXMOV_REG_W-1:0] MAXMOV_RST = 16'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_MAXMOV = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> rtl/core/dmf_line_buf.sv
// One line buffer: a row of window-column history with a registered read port.
`default_nettype none

module dmf_line_buf #(
  parameter int DEPTH = dmf_pkg::MAX_WIDTH_DEF,
  parameter int AW    = 10,
  parameter int EW    = 17
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [EW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [EW-1:0] rdata_o
);
  import dmf_pkg::*;

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A write in the same cycle to the same column is forwarded to the reader.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/dmf_col_cell.sv
// One window column cell: holds a column of samples and hands it to the next cell.
`default_nettype none

module dmf_col_cell #(
  parameter int N  = 7,
  parameter int EW = 17
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [N-1:0][EW-1:0] col_i,
  output logic      [N-1:0][EW-1:0] col_o
);
  import dmf_pkg::*;

  logic [N-1:0][EW-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

>>> rtl/core/dmf_rank_cell.sv
// One rank cell: counts the window samples below and not above its own sample.
`default_nettype none

module dmf_rank_cell #(
  parameter int IDX = 0,
  parameter int N   = 7,
  parameter int NC  = 49,
  parameter int DB  = 16,
  parameter int CW  = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [NC-1:0][DB-1:0] vals_i,
  input  wire logic [NC-1:0]        ok_i,
  output logic      [CW-1:0]        lt_o,
  output logic      [CW-1:0]        le_o
);
  import dmf_pkg::*;

  localparam int GW = $clog2(N + 1);

  logic [NC-1:0]         lt_bits_q, le_bits_q;
  logic [N-1:0][GW-1:0]  lt_grp_d, le_grp_d, lt_grp_q, le_grp_q;
  logic [CW-1:0]         lt_d, le_d, lt_q, le_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NC; j++) begin
        lt_bits_q[j] <= ok_i[j] && (vals_i[j] <  vals_i[IDX]);
        le_bits_q[j] <= ok_i[j] && (vals_i[j] <= vals_i[IDX]);
      end
    end
  end

  always_comb begin
    for (int g = 0; g < N; g++) begin
      lt_grp_d[g] = '0;
      le_grp_d[g] = '0;
      for (int j = 0; j < N; j++) begin
        lt_grp_d[g] = lt_grp_d[g] + GW'(lt_bits_q[g*N+j]);
        le_grp_d[g] = le_grp_d[g] + GW'(le_bits_q[g*N+j]);
      end
    end
  end

  always_comb begin
    lt_d = '0;
    le_d = '0;
    for (int g = 0; g < N; g++) begin
      lt_d = lt_d + CW'(lt_grp_q[g]);
      le_d = le_d + CW'(le_grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lt_grp_q <= lt_grp_d;
      le_grp_q <= le_grp_d;
      lt_q     <= lt_d;
      le_q     <= le_d;
    end
  end

  assign lt_o = lt_q;
  assign le_o = le_q;

endmodule

`default_nettype wire

>>> rtl/core/depth_median_clamped_filter.sv
// Top level of the depth median filter with a movement limit.
// The depth image enters on the s_axis channel in raster order, one word per pixel:
// tdata carries the depth, tuser bit 0 the sample-valid flag and bit 1 the flush flag.
// After the last pixel of a frame, R*W+R flush words drain the remaining rows.
// Filtered pixels leave on the m_axis channel: tdata holds the depth, tuser the
// validity copied from the input pixel and tlast marks the final pixel of the frame.
// The result for a pixel is computed from the window once the input word R*W+R positions
// later is accepted; earlier words of a frame give no output word.
// The block takes one word per cycle if not stalled; a chain of window column cells,
// fed by 2*MAX_RADIUS line buffers, and a bank of pipelined rank cells form the median.
// When the receiver stalls, the whole pipeline holds and s_axis_tready_o falls;
// the input stays blocked for as long as an output word waits to be taken.
// Registers are written on the cfg channel (index 0 width, 1 height, 2 radius,
// 3 movement limit); width, height and radius writes restart the frame.
// Reset clears the pipeline, restores the default registers and starts a new frame;
// line buffer contents need no clearing as out-of-frame samples are masked.
`default_nettype none

module depth_median_clamped_filter #(
  parameter int MAX_WIDTH  = dmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dmf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = dmf_pkg::MAX_RADIUS_DEF,
  parameter int DEPTH_BITS = dmf_pkg::DEPTH_BITS_DEF,
  parameter int TDW        = ((DEPTH_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [TDW-1:0]                  s_axis_tdata_i,  // depth_in
  input  wire logic [1:0]                      s_axis_tuser_i,  // sample_valid, flush
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [TDW-1:0]                  m_axis_tdata_o,  // depth_out
  output logic                                 m_axis_tuser_o,  // valid_out
  output logic                                 m_axis_tlast_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dmf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [dmf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dmf_pkg::*;

  localparam int N   = 2 * MAX_RADIUS + 1;
  localparam int NC  = N * N;
  localparam int NL  = 2 * MAX_RADIUS;
  localparam int DB  = DEPTH_BITS;
  localparam int EW  = DB + 1;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int IW  = $clog2(N);
  localparam int DLW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CW  = $clog2(NC + 1);
  localparam int GW  = $clog2(N + 1);
  localparam int MVW = (DB > MAXMOV_REG_W) ? DB : MAXMOV_REG_W;

  // Configuration registers.
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [RADIUS_REG_W-1:0] radius_q;
  logic [MAXMOV_REG_W-1:0] maxmov_q;
  logic                    cfg_we, restart;

  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [RW-1:0]  eff_r;
  logic [DLW-1:0] d_val;

  // Stream position.
  logic [DLW-1:0] d_cnt_q;
  logic [WW-1:0]  q_col_q;
  logic [HW-1:0]  q_row_q;
  logic [AW-1:0]  p_col_q;
  logic           emit, q_last, acc, adv;

  // Pipeline valid bits, stage 8 is the output register.
  logic [8:1]     vld_q;

  logic [EW-1:0]  smp0;
  logic [EW-1:0]  smp1_q;
  logic [AW-1:0]  col1_q;
  logic           emit1_q, last1_q;
  logic [WW-1:0]  qcol1_q, qcol2_q;
  logic [HW-1:0]  qrow1_q, qrow2_q;
  logic           last2_q;

  logic [NL-1:0][EW-1:0]       rd;
  logic [N-1:0][EW-1:0]        colv;
  logic [N-1:0][N-1:0][EW-1:0] win;
  logic                        shift_en;

  logic [NC-1:0][DB-1:0] vals_q [3:6];
  logic [NC-1:0]         ok_q   [3:6];
  logic [NC-1:0][DB-1:0] vals3_d;
  logic [NC-1:0]         ok3_d;
  logic [EW-1:0]         cen_q  [3:7];
  logic                  lst_q  [3:7];
  logic [IW-1:0]         ridx;

  logic [NC-1:0][CW-1:0] lt6, le6;
  logic [N-1:0][GW-1:0]  grp_d, grp5_q;
  logic [CW-1:0]         cnt_d, cnt6_q, half;
  logic [DB-1:0]         med_d, med7_q;
  logic [DB-1:0]         res_d, out_depth_q;
  logic                  out_vld_flag_q, out_last_q;

  // Register writes.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_WIDTH, REG_HEIGHT, REG_RADIUS: restart = 1'b1;
        default:                            restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      radius_q <= RADIUS_RST;
      maxmov_q <= MAXMOV_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        REG_RADIUS: radius_q <= cfg_data_i[RADIUS_REG_W-1:0];
        REG_MAXMOV: maxmov_q <= cfg_data_i[MAXMOV_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
    if (int'(radius_q) > MAX_RADIUS) begin
      eff_r = RW'(MAX_RADIUS);
    end else begin
      eff_r = RW'(radius_q);
    end
  end

  assign d_val = DLW'(eff_r) * DLW'(eff_w) + DLW'(eff_r);

  // Handshake and position counters.
  assign adv             = !vld_q[8] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign acc             = s_axis_tvalid_i && adv;
  assign emit            = (d_cnt_q == d_val);
  assign q_last          = emit && (q_row_q == eff_h - HW'(1)) && (q_col_q == eff_w - WW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_cnt_q <= '0;
      q_col_q <= '0;
      q_row_q <= '0;
      p_col_q <= '0;
    end else if (restart) begin
      d_cnt_q <= '0;
      q_col_q <= '0;
      q_row_q <= '0;
      p_col_q <= '0;
    end else if (acc) begin
      if (q_last) begin
        d_cnt_q <= '0;
        q_col_q <= '0;
        q_row_q <= '0;
        p_col_q <= '0;
      end else begin
        if (!emit) begin
          d_cnt_q <= d_cnt_q + DLW'(1);
        end else if (q_col_q == eff_w - WW'(1)) begin
          q_col_q <= '0;
          q_row_q <= q_row_q + HW'(1);
        end else begin
          q_col_q <= q_col_q + WW'(1);
        end
        if (WW'(p_col_q) == eff_w - WW'(1)) begin
          p_col_q <= '0;
        end else begin
          p_col_q <= p_col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q[1] <= acc;
      vld_q[2] <= vld_q[1] && emit1_q;
      for (int s = 3; s <= 8; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Stage 1: sample word and line buffer reads.
  assign smp0 = s_axis_tuser_i[1] ? '0 : {s_axis_tuser_i[0], s_axis_tdata_i[DB-1:0]};

  always_ff @(posedge clk_i) begin
    if (acc) begin
      smp1_q  <= smp0;
      col1_q  <= p_col_q;
      emit1_q <= emit;
      last1_q <= q_last;
      qcol1_q <= q_col_q;
      qrow1_q <= q_row_q;
    end
  end

  assign shift_en = vld_q[1] && adv;

  always_comb begin
    colv[0] = smp1_q;
    for (int k = 1; k < N; k++) begin
      colv[k] = rd[k-1];
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_line
    dmf_line_buf #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .EW    (EW)
    ) u_line_buf (
      .clk_i   (clk_i),
      .we_i    (shift_en),
      .waddr_i (col1_q),
      .wdata_i (colv[k]),
      .re_i    (acc),
      .raddr_i (p_col_q),
      .rdata_o (rd[k])
    );
  end

  // Stage 2: the window, a chain of column cells.
  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j == 0) begin : g_first
      dmf_col_cell #(.N(N), .EW(EW)) u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .col_i (colv),
        .col_o (win[j])
      );
    end else begin : g_next
      dmf_col_cell #(.N(N), .EW(EW)) u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .col_i (win[j-1]),
        .col_o (win[j])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      qcol2_q <= qcol1_q;
      qrow2_q <= qrow1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 3: mask the window to the frame and the chosen radius.
  assign ridx = IW'(eff_r);

  always_comb begin
    int rr;
    int cc;
    int r2;
    r2 = 2 * int'(eff_r);
    for (int k = 0; k < N; k++) begin
      for (int j = 0; j < N; j++) begin
        rr = int'(qrow2_q) + int'(eff_r) - k;
        cc = int'(qcol2_q) + int'(eff_r) - j;
        vals3_d[k*N+j] = win[j][k][DB-1:0];
        ok3_d[k*N+j]   = win[j][k][DB] && (k <= r2) && (j <= r2) &&
                         (rr >= 0) && (rr < int'(eff_h)) &&
                         (cc >= 0) && (cc < int'(eff_w));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vals_q[3] <= vals3_d;
      ok_q[3]   <= ok3_d;
      cen_q[3]  <= win[ridx][ridx];
      lst_q[3]  <= last2_q;
      for (int s = 4; s <= 6; s++) begin
        vals_q[s] <= vals_q[s-1];
        ok_q[s]   <= ok_q[s-1];
      end
      for (int s = 4; s <= 7; s++) begin
        cen_q[s] <= cen_q[s-1];
        lst_q[s] <= lst_q[s-1];
      end
    end
  end

  // Stages 4 to 6: ranks and the count of usable samples.
  for (genvar i = 0; i < NC; i++) begin : g_rank
    dmf_rank_cell #(
      .IDX (i),
      .N   (N),
      .NC  (NC),
      .DB  (DB),
      .CW  (CW)
    ) u_rank (
      .clk_i  (clk_i),
      .en_i   (adv),
      .vals_i (vals_q[3]),
      .ok_i   (ok_q[3]),
      .lt_o   (lt6[i]),
      .le_o   (le6[i])
    );
  end

  always_comb begin
    for (int g = 0; g < N; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < N; j++) begin
        grp_d[g] = grp_d[g] + GW'(ok_q[4][g*N+j]);
      end
    end
    cnt_d = '0;
    for (int g = 0; g < N; g++) begin
      cnt_d = cnt_d + CW'(grp5_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grp5_q <= grp_d;
      cnt6_q <= cnt_d;
    end
  end

  // Stage 7: the upper median is the sample whose rank range covers count/2.
  assign half = cnt6_q >> 1;

  always_comb begin
    med_d = '0;
    for (int i = 0; i < NC; i++) begin
      if (ok_q[6][i] && (lt6[i] <= half) && (le6[i] > half)) begin
        med_d = med_d | vals_q[6][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      med7_q <= med_d;
    end
  end

  // Stage 8: limit the movement and load the output register.
  always_comb begin
    logic [MVW-1:0] origx, medx, mmx, diff;
    origx = MVW'(cen_q[7][DB-1:0]);
    medx  = MVW'(med7_q);
    mmx   = MVW'(maxmov_q);
    diff  = '0;
    if (!cen_q[7][DB]) begin
      res_d = cen_q[7][DB-1:0];
    end else if (medx >= origx) begin
      diff = medx - origx;
      if (diff < mmx) begin
        res_d = med7_q;
      end else if (medx == origx) begin
        res_d = cen_q[7][DB-1:0];
      end else begin
        res_d = DB'(origx + mmx);
      end
    end else begin
      diff = origx - medx;
      if (diff < mmx) begin
        res_d = med7_q;
      end else begin
        res_d = DB'(origx - mmx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_depth_q    <= res_d;
      out_vld_flag_q <= cen_q[7][DB];
      out_last_q     <= lst_q[7];
    end
  end

  assign m_axis_tvalid_o = vld_q[8];
  assign m_axis_tdata_o  = TDW'(out_depth_q);
  assign m_axis_tuser_o  = out_vld_flag_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  a_delay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_cnt_q <= d_val)
    else $error("Start-up count has passed the window delay.");

  a_in_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(p_col_q) < eff_w)
    else $error("Input column is outside the row.");

  a_centre_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_col_q < eff_w) && (q_row_q < eff_h))
    else $error("Centre position is outside the frame.");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && q_last |=> (d_cnt_q == '0) && (p_col_q == '0))
    else $error("Frame did not restart after its final pixel.");

  a_median_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] && cen_q[6][DB] |-> (cnt6_q != '0))
    else $error("Valid centre found an empty window.");
`endif

endmodule

`default_nettype wire

>>> dv/depth_median_clamped_filter_test.sv
// Testbench for the depth median filter with movement limit: directed and random frames.
`default_nettype none

module depth_median_clamped_filter_test;
  import dmf_pkg::*;

  typedef struct packed {
    logic [15:0] depth;
    logic        valid;
    logic        last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  depth_median_clamped_filter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter state as the block should hold it.
  int unsigned      cur_width = 640, cur_height = 480, cur_radius = 1, cur_limit = 100;
  int unsigned      position;
  logic [16:0]      frame_store [int];
  pixel_t           pending [$];
  int unsigned      words_sent, pixels_checked, frames_sent, mismatches, idle_cycles;
  bit               calm;

  function automatic int unsigned eff_width();
    if (cur_width == 0) return 1;
    return cur_width > 1024 ? 1024 : cur_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cur_height == 0) return 1;
    return cur_height > 1024 ? 1024 : cur_height;
  endfunction

  function automatic logic [15:0] filtered_depth(int unsigned q);
    int unsigned w, h, cnt, med, orig, v, j;
    int          row, col, rr, cc;
    int unsigned vals [49];
    logic [16:0] e;
    w = eff_width();
    h = eff_height();
    cnt = 0;
    orig = frame_store[q][15:0];
    if (!frame_store[q][16]) return orig[15:0];
    row = q / w;
    col = q % w;
    for (int dy = -int'(cur_radius); dy <= int'(cur_radius); dy++) begin
      for (int dx = -int'(cur_radius); dx <= int'(cur_radius); dx++) begin
        rr = row + dy;
        cc = col + dx;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
          e = frame_store[rr * w + cc];
          if (e[16]) begin
            vals[cnt] = e[15:0];
            cnt++;
          end
        end
      end
    end
    for (int i = 1; i < cnt; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    med = vals[cnt/2];
    if (med >= orig) begin
      if (med - orig < cur_limit) return med[15:0];
      return (med == orig) ? orig[15:0] : 16'(orig + cur_limit);
    end
    if (orig - med < cur_limit) return med[15:0];
    return 16'(orig - cur_limit);
  endfunction

  function automatic void advance_frame(logic [15:0] depth, logic valid, logic flush);
    int unsigned w, pixels, lag;
    pixel_t      px;
    w = eff_width();
    pixels = eff_height() * w;
    lag = cur_radius * w + cur_radius;
    if (position < pixels) frame_store[position] = flush ? 17'd0 : {valid, depth};
    if (position >= lag && position - lag < pixels) begin
      px.depth = filtered_depth(position - lag);
      px.valid = frame_store[position - lag][16];
      px.last  = (position - lag == pixels - 1);
      pending = {pending, px};
    end
    if (position + 1 >= pixels + lag) begin
      position = 0;
      frame_store.delete();
    end else begin
      position++;
    end
  endfunction

  task automatic send_word(logic [15:0] depth, logic valid, logic flush);
    if (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= depth;
    s_axis_tuser_i  <= {flush, valid};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    advance_frame(depth, valid, flush);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value[15:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_WIDTH:  cur_width  = value & 16'h7FF;
      REG_HEIGHT: cur_height = value & 16'h7FF;
      REG_RADIUS: cur_radius = value & 2'h3;
      REG_MAXMOV: cur_limit  = value & 16'hFFFF;
      default: ;
    endcase
    if (idx != REG_MAXMOV) begin
      position = 0;
      frame_store.delete();
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r, int unsigned mm);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_MAXMOV, mm);
  endtask

  // Sends a whole frame and its drain; noise puts stray samples into drain positions.
  task automatic send_frame(int unsigned spread, int unsigned noise);
    int unsigned w, pixels, lag, base;
    logic [15:0] d;
    w = eff_width();
    pixels = eff_height() * w;
    lag = cur_radius * w + cur_radius;
    base = $urandom_range(65535);
    for (int unsigned i = 0; i < pixels; i++) begin
      case ($urandom_range(19))
        0:       d = 16'h0000;
        1:       d = 16'hFFFF;
        2:       d = 16'($urandom_range(65535));
        default: d = 16'(base + $urandom_range(spread) - spread / 2);
      endcase
      send_word(d, $urandom_range(99) < 85, $urandom_range(99) < 5);
    end
    for (int unsigned i = 0; i < lag; i++)
      send_word(16'($urandom_range(65535)), 1'($urandom_range(1)),
                $urandom_range(99) >= noise);
    frames_sent++;
  endtask

  task automatic test_directed();
    set_frame(4, 3, 1, 100);
    send_word(16'h0000, 1, 0); send_word(16'hFFFF, 1, 0); send_word(16'd500, 1, 0);
    send_word(16'd520, 0, 0);  send_word(16'd480, 1, 0);  send_word(16'd9000, 1, 0);
    send_word(16'd490, 1, 0);  send_word(16'd510, 1, 1);  send_word(16'd505, 1, 0);
    send_word(16'd400, 0, 0);  send_word(16'd530, 1, 0);  send_word(16'hFFFF, 1, 0);
    send_word(16'h1234, 1, 0); send_word(16'd7, 0, 1);    send_word(16'hABCD, 1, 0);
    send_word(16'd0, 0, 1);    send_word(16'hFFFF, 1, 0);
    frames_sent++;
  endtask

  task automatic test_zero_limit();
    set_frame(3, 3, 1, 0);
    for (int i = 0; i < 9; i++) send_word(i == 4 ? 16'd800 : 16'd777, 1, 0);
    for (int i = 0; i < 4; i++) send_word(16'd0, 0, 1);
    frames_sent++;
  endtask

  task automatic test_size_limits();
    set_frame(0, 0, 3, 65535);
    send_frame(100, 50);
    set_frame(7, 7, 3, 1);
    send_frame(200, 0);
    set_frame(2047, 1, 0, 300);
    calm = 1'b1;
    send_frame(600, 0);
    calm = 1'b0;
    write_reg(REG_HEIGHT, 2047);
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 2);
    send_frame(600, 0);
  endtask

  task automatic test_random();
    int unsigned mm;
    while (words_sent < 1150) begin
      case ($urandom_range(3))
        0: mm = 0;
        1: mm = $urandom_range(1, 50);
        2: mm = 65535;
        default: mm = $urandom_range(65535);
      endcase
      set_frame($urandom_range(1, 16), $urandom_range(1, 10), $urandom_range(3), mm);
      calm = (frames_sent % 9 == 4);
      send_frame($urandom_range(1, 4) * 64, 10);
      calm = 1'b0;
      if (frames_sent % 5 == 0) begin
        // Hold the stream until every outstanding pixel is back.
        s_axis_tvalid_i <= 1'b0;
        while (pending.size() != 0) @(negedge clk_i);
        @(negedge clk_i);
        send_frame(128, 10);
      end
    end
  endtask

  always @(negedge clk_i)
    m_axis_tready_i <= calm || $urandom_range(99) >= 30;

  always @(posedge clk_i) begin
    pixel_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel depth=%0d valid=%0b last=%0b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata_o !== want.depth) begin
          $display("%0t: depth expected %0d actual %0d", $time, want.depth, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== want.valid) begin
          $display("%0t: valid expected %0b actual %0b", $time, want.valid, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast_o);
          mismatches++;
        end
        pixels_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("%0t: no progress, %0d pixels outstanding", $time, pending.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_zero_limit();
    test_size_limits();
    test_random();
    settle();
    $display("Sent %0d words in %0d frames and checked %0d filtered pixels.",
             words_sent, frames_sent, pixels_checked);
    $display("Sizes ran from one pixel to full width, with every radius and limit extremes.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/dmf_pkg.sv
rtl/core/dmf_line_buf.sv
rtl/core/dmf_col_cell.sv
rtl/core/dmf_rank_cell.sv
rtl/core/depth_median_clamped_filter.sv
dv/depth_median_clamped_filter_test.sv
